// ----- design/typed_integer_alu_unit_macros.svh -----
// assertion macros for the typed integer alu
// used by the rtl module that carries concurrent checks
`ifndef TYPED_INTEGER_ALU_UNIT_MACROS_SVH
`define TYPED_INTEGER_ALU_UNIT_MACROS_SVH
`ifndef SYNTH
`define TIAL_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");
`define TIAL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define TIAL_ASSERT_IMPL(lbl, ante, cons)
`define TIAL_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- design/tial_pkg.sv -----
// types, codes and helper functions for the typed integer alu
// no dependencies
`default_nettype none
package tial_pkg;
  localparam int DATA_W = 64;
  localparam int OP_W   = 5;
  localparam int TYPE_W = 3;

  localparam logic [OP_W-1:0] OP_ADD  = 5'd0;
  localparam logic [OP_W-1:0] OP_SUB  = 5'd1;
  localparam logic [OP_W-1:0] OP_MUL  = 5'd2;
  localparam logic [OP_W-1:0] OP_DIV  = 5'd3;
  localparam logic [OP_W-1:0] OP_MOD  = 5'd4;
  localparam logic [OP_W-1:0] OP_AND  = 5'd5;
  localparam logic [OP_W-1:0] OP_OR   = 5'd6;
  localparam logic [OP_W-1:0] OP_XOR  = 5'd7;
  localparam logic [OP_W-1:0] OP_SHL  = 5'd8;
  localparam logic [OP_W-1:0] OP_SHR  = 5'd9;
  localparam logic [OP_W-1:0] OP_EQ   = 5'd10;
  localparam logic [OP_W-1:0] OP_NE   = 5'd11;
  localparam logic [OP_W-1:0] OP_LT   = 5'd12;
  localparam logic [OP_W-1:0] OP_LE   = 5'd13;
  localparam logic [OP_W-1:0] OP_GT   = 5'd14;
  localparam logic [OP_W-1:0] OP_GE   = 5'd15;
  localparam logic [OP_W-1:0] OP_LAND = 5'd16;
  localparam logic [OP_W-1:0] OP_LOR  = 5'd17;
  localparam logic [OP_W-1:0] OP_CONV = 5'd18;

  localparam logic [1:0] SEL_SIMPLE = 2'd0;
  localparam logic [1:0] SEL_MUL    = 2'd1;
  localparam logic [1:0] SEL_DIV    = 2'd2;
  localparam logic [1:0] SEL_MOD    = 2'd3;

  // what rides along the divider pipeline beside the quotient
  typedef struct packed {
    logic [1:0]        sel;
    logic [1:0]        wcode;
    logic [DATA_W-1:0] simple;
    logic              is_bool;
    logic              fault;
    logic              neg_q;
    logic              neg_r;
    logic [DATA_W-1:0] p_lo;
    logic [31:0]       p_mid_a;
    logic [31:0]       p_mid_b;
  } side_t;

  function automatic logic [DATA_W-1:0] width_mask(input logic [1:0] wcode);
    logic [DATA_W-1:0] m;
    case (wcode)
      2'd0:    m = 64'h0000_0000_0000_00ff;
      2'd1:    m = 64'h0000_0000_0000_ffff;
      2'd2:    m = 64'h0000_0000_ffff_ffff;
      default: m = 64'hffff_ffff_ffff_ffff;
    endcase
    return m;
  endfunction

  function automatic logic [DATA_W-1:0] sign_ext(input logic [DATA_W-1:0] v,
                                                 input logic [1:0] wcode);
    logic [DATA_W-1:0] r;
    case (wcode)
      2'd0:    r = {{56{v[7]}}, v[7:0]};
      2'd1:    r = {{48{v[15]}}, v[15:0]};
      2'd2:    r = {{32{v[31]}}, v[31:0]};
      default: r = v;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- design/tial_if.sv -----
// valid/ready channel interfaces for the typed integer alu
// depends on tial_pkg
`default_nettype none
interface tial_in_if;
  logic                         valid;
  logic                         ready;
  logic [tial_pkg::OP_W-1:0]    op;
  logic [tial_pkg::TYPE_W-1:0]  operand_type;
  logic [tial_pkg::DATA_W-1:0]  operand_a;
  logic [tial_pkg::DATA_W-1:0]  operand_b;
  logic [tial_pkg::TYPE_W-1:0]  target_type;
  modport source (output valid, op, operand_type, operand_a, operand_b, target_type,
                  input ready);
  modport sink (input valid, op, operand_type, operand_a, operand_b, target_type,
                output ready);
endinterface

interface tial_out_if;
  logic                        valid;
  logic                        ready;
  logic [tial_pkg::DATA_W-1:0] result;
  logic                        is_bool;
  logic                        fault;
  modport source (output valid, result, is_bool, fault, input ready);
  modport sink (input valid, result, is_bool, fault, output ready);
endinterface
`default_nettype wire

// ----- design/tial_div.sv -----
// pipelined restoring divider, one quotient bit per stage, with sideband
// depends on tial_pkg
`default_nettype none
module tial_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire logic [tial_pkg::DATA_W-1:0] dividend,
  input  wire logic [tial_pkg::DATA_W-1:0] divisor,
  input  wire tial_pkg::side_t             side_in,
  output logic                             out_valid,
  output logic [tial_pkg::DATA_W-1:0]      quotient,
  output logic [tial_pkg::DATA_W-1:0]      remainder,
  output tial_pkg::side_t                  side_out
);
  localparam int W = tial_pkg::DATA_W;

  logic [W-1:0]    rem_r  [W];
  logic [W-1:0]    num_r  [W];
  logic [W-1:0]    quo_r  [W];
  logic [W-1:0]    den_r  [W];
  tial_pkg::side_t side_r [W];
  logic            vld_r  [W];

  genvar k;
  generate
    for (k = 0; k < W; k++) begin : g_stage
      logic [W-1:0]    rem_p, num_p, quo_p, den_p;
      tial_pkg::side_t side_p;
      logic            vld_p;
      logic [W:0]      shifted;
      logic [W+1:0]    diff;
      logic            ge;
      if (k == 0) begin : g_first
        assign rem_p  = '0;
        assign num_p  = dividend;
        assign quo_p  = '0;
        assign den_p  = divisor;
        assign side_p = side_in;
        assign vld_p  = in_valid;
      end else begin : g_next
        assign rem_p  = rem_r[k-1];
        assign num_p  = num_r[k-1];
        assign quo_p  = quo_r[k-1];
        assign den_p  = den_r[k-1];
        assign side_p = side_r[k-1];
        assign vld_p  = vld_r[k-1];
      end
      // trial subtract of the shifted partial remainder
      assign shifted = {rem_p, num_p[W-1]};
      assign diff    = {1'b0, shifted} - {2'b00, den_p};
      assign ge      = ~diff[W+1];

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k] <= 1'b0;
        end else if (en) begin
          vld_r[k] <= vld_p;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k]  <= ge ? diff[W-1:0] : shifted[W-1:0];
          num_r[k]  <= {num_p[W-2:0], 1'b0};
          quo_r[k]  <= {quo_p[W-2:0], ge};
          den_r[k]  <= den_p;
          side_r[k] <= side_p;
        end
      end
    end
  endgenerate

  assign out_valid = vld_r[W-1];
  assign quotient  = quo_r[W-1];
  assign remainder = rem_r[W-1];
  assign side_out  = side_r[W-1];
endmodule
`default_nettype wire

// ----- design/typed_integer_alu_unit.sv -----
// Typed integer ALU, fully pipelined: one item is accepted every cycle while the
// output is not stalled (67 register stages: input register, decode stage, a
// 64-stage restoring divider that every item flows through, and the output register).
// The whole pipeline advances together whenever the output register is empty
// or being taken, so a stall at the output holds every stage in place.
// Depends on tial_pkg, tial_if, tial_div and the macros header.
`default_nettype none
`include "typed_integer_alu_unit_macros.svh"
module typed_integer_alu_unit (
  input  wire logic   clk,
  input  wire logic   rst_n,
  tial_in_if.sink     in_ch,
  tial_out_if.source  out_ch
);
  localparam int W = tial_pkg::DATA_W;

  logic en;
  logic out_valid_r;
  logic [W-1:0] out_result_r;
  logic out_is_bool_r, out_fault_r;

  // global advance: output register free or being drained
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // stage a: capture and truncate operands
  logic                         a_valid_r;
  logic [tial_pkg::OP_W-1:0]    a_op_r;
  logic [1:0]                   a_wcode_r, a_twcode_r;
  logic                         a_sg_r, a_tsg_r;
  logic [W-1:0]                 a_x_r, a_y_r, a_raw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_op_r     <= in_ch.op;
      a_wcode_r  <= in_ch.operand_type[1:0];
      a_sg_r     <= ~in_ch.operand_type[2];
      a_twcode_r <= in_ch.target_type[1:0];
      a_tsg_r    <= ~in_ch.target_type[2];
      a_x_r      <= in_ch.operand_a & tial_pkg::width_mask(in_ch.operand_type[1:0]);
      a_y_r      <= in_ch.operand_b & tial_pkg::width_mask(in_ch.operand_type[1:0]);
      a_raw_r    <= in_ch.operand_a;
    end
  end

  // stage b logic: simple ops, divider setup, multiplier partial products
  logic [W-1:0]    m_a, sx, sy, bx, by, ma, mb, conv_raw;
  logic [5:0]      sh;
  logic            lt, eq, na, nb, y_zero;
  tial_pkg::side_t side_b;

  always_comb begin
    m_a      = tial_pkg::width_mask(a_wcode_r);
    sx       = a_sg_r ? tial_pkg::sign_ext(a_x_r, a_wcode_r) : a_x_r;
    sy       = a_sg_r ? tial_pkg::sign_ext(a_y_r, a_wcode_r) : a_y_r;
    sh       = a_y_r[5:0] & ((6'd8 << a_wcode_r) - 6'd1);
    bx       = a_sg_r ? {~sx[W-1], sx[W-2:0]} : a_x_r;
    by       = a_sg_r ? {~sy[W-1], sy[W-2:0]} : a_y_r;
    lt       = bx < by;
    eq       = a_x_r == a_y_r;
    na       = a_sg_r & sx[W-1];
    nb       = a_sg_r & sy[W-1];
    ma       = na ? (W'(0) - sx) : a_x_r;
    mb       = nb ? (W'(0) - sy) : a_y_r;
    y_zero   = a_y_r == '0;
    conv_raw = a_raw_r & tial_pkg::width_mask(a_twcode_r);

    side_b.sel     = tial_pkg::SEL_SIMPLE;
    side_b.wcode   = a_wcode_r;
    side_b.simple  = '0;
    side_b.is_bool = 1'b0;
    side_b.fault   = 1'b0;
    side_b.neg_q   = na ^ nb;
    side_b.neg_r   = na;
    side_b.p_lo    = {32'd0, a_x_r[31:0]} * {32'd0, a_y_r[31:0]};
    side_b.p_mid_a = a_x_r[31:0] * a_y_r[63:32];
    side_b.p_mid_b = a_x_r[63:32] * a_y_r[31:0];

    case (a_op_r)
      tial_pkg::OP_ADD: side_b.simple = (a_x_r + a_y_r) & m_a;
      tial_pkg::OP_SUB: side_b.simple = (a_x_r - a_y_r) & m_a;
      tial_pkg::OP_MUL: side_b.sel = tial_pkg::SEL_MUL;
      tial_pkg::OP_DIV, tial_pkg::OP_MOD: begin
        if (y_zero) begin
          side_b.fault = 1'b1;
        end else begin
          side_b.sel = (a_op_r == tial_pkg::OP_DIV) ? tial_pkg::SEL_DIV
                                                     : tial_pkg::SEL_MOD;
        end
      end
      tial_pkg::OP_AND: side_b.simple = a_x_r & a_y_r;
      tial_pkg::OP_OR:  side_b.simple = a_x_r | a_y_r;
      tial_pkg::OP_XOR: side_b.simple = a_x_r ^ a_y_r;
      tial_pkg::OP_SHL: side_b.simple = (a_x_r << sh) & m_a;
      tial_pkg::OP_SHR: begin
        if (na) begin
          side_b.simple = W'($signed(sx) >>> sh) & m_a;
        end else begin
          side_b.simple = a_x_r >> sh;
        end
      end
      tial_pkg::OP_EQ: begin
        side_b.simple = {63'd0, eq};
        side_b.is_bool = 1'b1;
      end
      tial_pkg::OP_NE: begin
        side_b.simple = {63'd0, !eq};
        side_b.is_bool = 1'b1;
      end
      tial_pkg::OP_LT: begin
        side_b.simple = {63'd0, lt};
        side_b.is_bool = 1'b1;
      end
      tial_pkg::OP_LE: begin
        side_b.simple = {63'd0, lt || eq};
        side_b.is_bool = 1'b1;
      end
      tial_pkg::OP_GT: begin
        side_b.simple = {63'd0, !lt && !eq};
        side_b.is_bool = 1'b1;
      end
      tial_pkg::OP_GE: begin
        side_b.simple = {63'd0, !lt};
        side_b.is_bool = 1'b1;
      end
      tial_pkg::OP_LAND: begin
        side_b.simple = {63'd0, (a_x_r != '0) && !y_zero};
        side_b.is_bool = 1'b1;
      end
      tial_pkg::OP_LOR: begin
        side_b.simple = {63'd0, (a_x_r != '0) || !y_zero};
        side_b.is_bool = 1'b1;
      end
      tial_pkg::OP_CONV: begin
        side_b.simple = a_tsg_r ? tial_pkg::sign_ext(conv_raw, a_twcode_r) : conv_raw;
      end
      default: side_b.simple = '0;
    endcase
  end

  // stage b registers
  logic            b_valid_r;
  logic [W-1:0]    b_ma_r, b_mb_r;
  tial_pkg::side_t b_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_ma_r   <= ma;
      b_mb_r   <= mb;
      b_side_r <= side_b;
    end
  end

  // divider pipeline, every item passes through it
  logic            d_valid;
  logic [W-1:0]    d_quo, d_rem;
  tial_pkg::side_t d_side;

  tial_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (b_valid_r),
    .dividend  (b_ma_r),
    .divisor   (b_mb_r),
    .side_in   (b_side_r),
    .out_valid (d_valid),
    .quotient  (d_quo),
    .remainder (d_rem),
    .side_out  (d_side)
  );

  // final select: product sum, signed fixup of quotient/remainder, or the simple result
  logic [W-1:0] m_d, prod, res_nxt;
  always_comb begin
    m_d  = tial_pkg::width_mask(d_side.wcode);
    prod = d_side.p_lo + {d_side.p_mid_a + d_side.p_mid_b, 32'd0};
    case (d_side.sel)
      tial_pkg::SEL_MUL: res_nxt = prod & m_d;
      tial_pkg::SEL_DIV: res_nxt = (d_side.neg_q ? (W'(0) - d_quo) : d_quo) & m_d;
      tial_pkg::SEL_MOD: res_nxt = (d_side.neg_r ? (W'(0) - d_rem) : d_rem) & m_d;
      default:           res_nxt = d_side.simple;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_result_r  <= res_nxt;
      out_is_bool_r <= d_side.is_bool;
      out_fault_r   <= d_side.fault;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.result  = out_result_r;
  assign out_ch.is_bool = out_is_bool_r;
  assign out_ch.fault   = out_fault_r;

  `TIAL_ASSERT_IMPL(a_fault_zero, out_valid_r && out_fault_r, (out_result_r == '0) && !out_is_bool_r)
  `TIAL_ASSERT_IMPL(a_bool_range, out_valid_r && out_is_bool_r, out_result_r[W-1:1] == '0)
  `TIAL_ASSERT_NEXT(a_accept_enters, in_ch.valid && en, a_valid_r)
endmodule
`default_nettype wire
